@@ sv/touch_gesture_recognizer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_unit_defines
// assertion macros used by the checker file tgr_checker
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_RECOGNIZER_UNIT_DEFINES_SVH
`define TOUCH_GESTURE_RECOGNIZER_UNIT_DEFINES_SVH

// checked outside reset
`define TGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TGR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tgr_pkg
// types and codes of the touch gesture recognizer
// ----------------------------------------------------------------------------
package tgr_pkg;

  typedef logic [3:0] gesture_t;

  localparam gesture_t G_TAP       = 4'd0;
  localparam gesture_t G_DOUBLE    = 4'd1;
  localparam gesture_t G_LONG      = 4'd2;
  localparam gesture_t G_LEFT      = 4'd3;
  localparam gesture_t G_RIGHT     = 4'd4;
  localparam gesture_t G_UP        = 4'd5;
  localparam gesture_t G_DOWN      = 4'd6;
  localparam gesture_t G_PINCH_IN  = 4'd7;
  localparam gesture_t G_PINCH_OUT = 4'd8;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DOWN   = 2'd1;
  localparam logic [1:0] PH_MOVING = 2'd2;

  localparam logic [1:0] CFG_SWIPE_MIN  = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [1:0] CFG_DOUBLE_TAP = 2'd2;
  localparam logic [1:0] CFG_PINCH_PCT  = 2'd3;

  localparam int CfgDataBits = 16;

  localparam logic [11:0] SWIPE_MIN_RESET  = 12'd50;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd400;
  localparam logic [15:0] DOUBLE_TAP_RESET = 16'd300;
  localparam logic [6:0]  PINCH_PCT_RESET  = 7'd20;

  localparam logic [6:0] PCT_SCALE = 7'd100;

  typedef struct packed {
    logic [11:0] swipe_min;
    logic [15:0] long_press_time;
    logic [15:0] double_tap_window;
    logic [6:0]  pinch_pct;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic emit;
    logic outward;
  } pinch_dec_t;

  typedef struct packed {
    logic [1:0] phase_next;
    logic       load_start;
    logic       cur_upd;
    logic       tap_store;
    logic       tap_clear;
    logic       emit;
    gesture_t   gesture;
  } touch_dec_t;

endpackage

@@ sv/tgr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tgr_cfg_regs
// configuration register file, one write beat per cycle
// ----------------------------------------------------------------------------
module tgr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [tgr_pkg::CfgDataBits-1:0]  cfg_data,
  output tgr_pkg::cfg_t                    cfg
);
  import tgr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swipe_min          <= SWIPE_MIN_RESET;
      cfg.long_press_time    <= LONG_PRESS_RESET;
      cfg.double_tap_window  <= DOUBLE_TAP_RESET;
      cfg.pinch_pct          <= PINCH_PCT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SWIPE_MIN:  cfg.swipe_min          <= cfg_data[11:0];
        CFG_LONG_PRESS: cfg.long_press_time    <= cfg_data[15:0];
        CFG_DOUBLE_TAP: cfg.double_tap_window  <= cfg_data[15:0];
        CFG_PINCH_PCT:  cfg.pinch_pct          <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/tgr_pinch.sv @@
// ----------------------------------------------------------------------------
// tgr_pinch
// two-finger distance against the latched reference, exact percent bound
// ----------------------------------------------------------------------------
module tgr_pinch #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]   first_x,
  input  logic [COORD_BITS-1:0]   first_y,
  input  logic [COORD_BITS-1:0]   second_x,
  input  logic [COORD_BITS-1:0]   second_y,
  input  logic [2*COORD_BITS:0]   reference,
  input  logic [6:0]              pct,
  output logic [2*COORD_BITS:0]   span_sq,
  output tgr_pkg::pinch_dec_t     dec
);
  import tgr_pkg::*;

  localparam int SqW = 2 * COORD_BITS + 1;
  localparam int PrW = SqW + 8;

  logic [COORD_BITS-1:0]   adx;
  logic [COORD_BITS-1:0]   ady;
  logic [2*COORD_BITS-1:0] sqx;
  logic [2*COORD_BITS-1:0] sqy;
  logic [7:0]              up_gain;
  logic [6:0]              dn_gain;
  logic [PrW-1:0]          dist_scaled;
  logic [PrW-1:0]          ref_up;
  logic [PrW-1:0]          ref_dn;
  logic                    grow;
  logic                    shrink;

  assign adx     = (second_x >= first_x) ? second_x - first_x : first_x - second_x;
  assign ady     = (second_y >= first_y) ? second_y - first_y : first_y - second_y;
  assign sqx     = adx * adx;
  assign sqy     = ady * ady;
  assign span_sq = {1'b0, sqx} + {1'b0, sqy};

  // d > r + floor(r*p/100)  <=>  100*d > r*(100+p), likewise for the lower bound
  assign up_gain     = {1'b0, PCT_SCALE} + {1'b0, pct};
  assign dn_gain     = PCT_SCALE - pct;
  assign dist_scaled = PrW'(span_sq) * PrW'(PCT_SCALE);
  assign ref_up      = PrW'(reference) * PrW'(up_gain);
  assign ref_dn      = PrW'(reference) * PrW'(dn_gain);

  assign grow   = dist_scaled > ref_up;
  assign shrink = (pct <= PCT_SCALE) && (dist_scaled < ref_dn);

  assign dec.latch   = (reference == '0);
  assign dec.emit    = !dec.latch && (grow || shrink);
  assign dec.outward = grow;

endmodule

@@ sv/tgr_touch.sv @@
// ----------------------------------------------------------------------------
// tgr_touch
// single-finger phase logic: tap, double tap, long press, swipe
// ----------------------------------------------------------------------------
module tgr_touch #(
  parameter int COORD_BITS = 12
) (
  input  tgr_pkg::cfg_t          cfg,
  input  logic [1:0]             phase,
  input  logic [COORD_BITS-1:0]  start_x,
  input  logic [COORD_BITS-1:0]  start_y,
  input  logic [31:0]            press_time,
  input  logic [31:0]            last_tap_time,
  input  logic                   pressed,
  input  logic [COORD_BITS-1:0]  pos_x,
  input  logic [COORD_BITS-1:0]  pos_y,
  input  logic [31:0]            time_ms,
  output tgr_pkg::touch_dec_t    dec
);
  import tgr_pkg::*;

  localparam int SqW  = 2 * COORD_BITS + 1;
  localparam int CmpW = (SqW > 24) ? SqW : 24;
  localparam int AbW  = (COORD_BITS > 12) ? COORD_BITS : 12;

  logic [COORD_BITS-1:0]   adx;
  logic [COORD_BITS-1:0]   ady;
  logic [2*COORD_BITS-1:0] sqx;
  logic [2*COORD_BITS-1:0] sqy;
  logic [SqW-1:0]          travel_sq;
  logic [23:0]             min_sq;
  logic [23:0]             quarter;
  logic                    travel_far;
  logic [31:0]             held;
  logic [31:0]             since_tap;
  logic                    x_far;
  logic                    y_far;

  assign adx       = (pos_x >= start_x) ? pos_x - start_x : start_x - pos_x;
  assign ady       = (pos_y >= start_y) ? pos_y - start_y : start_y - pos_y;
  assign sqx       = adx * adx;
  assign sqy       = ady * ady;
  assign travel_sq = {1'b0, sqx} + {1'b0, sqy};
  assign min_sq    = cfg.swipe_min * cfg.swipe_min;
  assign quarter   = min_sq >> 2;
  assign travel_far = CmpW'(travel_sq) > CmpW'(quarter);

  assign held      = time_ms - press_time;
  assign since_tap = time_ms - last_tap_time;

  assign x_far = AbW'(adx) >= AbW'(cfg.swipe_min);
  assign y_far = AbW'(ady) >= AbW'(cfg.swipe_min);

  always_comb begin
    dec            = '0;
    dec.phase_next = phase;
    dec.gesture    = G_TAP;
    unique case (phase)
      PH_IDLE: begin
        if (pressed) begin
          dec.phase_next = PH_DOWN;
          dec.load_start = 1'b1;
        end
      end
      PH_DOWN: begin
        dec.cur_upd = 1'b1;
        if (!pressed) begin
          dec.phase_next = PH_IDLE;
          dec.emit       = 1'b1;
          if ((last_tap_time != '0) && (since_tap < {16'd0, cfg.double_tap_window})) begin
            dec.gesture   = G_DOUBLE;
            dec.tap_clear = 1'b1;
          end else begin
            dec.gesture   = G_TAP;
            dec.tap_store = 1'b1;
          end
        end else begin
          if (travel_far) begin
            dec.phase_next = PH_MOVING;
          end
          if (held >= {16'd0, cfg.long_press_time}) begin
            dec.phase_next = PH_IDLE;
            dec.emit       = 1'b1;
            dec.gesture    = G_LONG;
          end
        end
      end
      PH_MOVING: begin
        dec.cur_upd = 1'b1;
        if (!pressed) begin
          dec.phase_next = PH_IDLE;
          if ((adx > ady) && x_far) begin
            dec.emit    = 1'b1;
            dec.gesture = (pos_x > start_x) ? G_RIGHT : G_LEFT;
          end else if ((ady >= adx) && y_far) begin
            dec.emit    = 1'b1;
            dec.gesture = (pos_y > start_y) ? G_DOWN : G_UP;
          end
        end
      end
      default: begin
        dec.phase_next = PH_IDLE;
      end
    endcase
  end

endmodule

@@ sv/touch_gesture_recognizer_unit.sv @@
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_unit
// tap, double tap, long press, swipe and pinch recognizer over touch reports
// ----------------------------------------------------------------------------
// One touch report is taken per cycle unless the output stalls. An accepted
// report sits in the input register, the pinch and single-finger logic work
// on it there, and any gesture is loaded into the output register when the
// input register advances. The input register advances whenever the output
// register is empty or being taken, so the input accepts a beat in every cycle
// while results are consumed. Reports with a zero point count and reports that
// make no gesture produce no output beat. Configuration writes are taken in any
// cycle and must only be issued while no report is in flight.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [tgr_pkg::CfgDataBits-1:0]  cfg_data,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [3:0]                       point_count,
  input  logic                             first_pressed,
  input  logic [COORD_BITS-1:0]            first_x,
  input  logic [COORD_BITS-1:0]            first_y,
  input  logic                             second_pressed,
  input  logic [COORD_BITS-1:0]            second_x,
  input  logic [COORD_BITS-1:0]            second_y,
  input  logic [31:0]                      time_ms,

  output logic                             out_valid,
  input  logic                             out_ready,
  output tgr_pkg::gesture_t                gesture,
  output logic [COORD_BITS-1:0]            begin_x,
  output logic [COORD_BITS-1:0]            begin_y,
  output logic [COORD_BITS-1:0]            finish_x,
  output logic [COORD_BITS-1:0]            finish_y,
  output logic [31:0]                      elapsed_ms
);
  import tgr_pkg::*;

  localparam int SqW = 2 * COORD_BITS + 1;

  cfg_t cfg;

  // input register
  logic                  hold_valid;
  logic [3:0]            hold_count;
  logic                  hold_p1;
  logic [COORD_BITS-1:0] hold_x;
  logic [COORD_BITS-1:0] hold_y;
  logic                  hold_p2;
  logic [COORD_BITS-1:0] hold_x2;
  logic [COORD_BITS-1:0] hold_y2;
  logic [31:0]           hold_time;

  // recognizer state
  logic [1:0]            phase;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [31:0]           press_time;
  logic [31:0]           last_tap_time;
  logic [SqW-1:0]        pinch_ref;

  logic                  advance;
  logic                  active;
  logic                  two_finger;
  logic [SqW-1:0]        span_sq;
  pinch_dec_t            pdec;
  touch_dec_t            tdec;
  logic [COORD_BITS-1:0] cur_x_next;
  logic [COORD_BITS-1:0] cur_y_next;
  logic                  emit;
  gesture_t              gesture_next;

  tgr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tgr_pinch #(.COORD_BITS(COORD_BITS)) u_pinch (
    .first_x   (hold_x),
    .first_y   (hold_y),
    .second_x  (hold_x2),
    .second_y  (hold_y2),
    .reference (pinch_ref),
    .pct       (cfg.pinch_pct),
    .span_sq   (span_sq),
    .dec       (pdec)
  );

  tgr_touch #(.COORD_BITS(COORD_BITS)) u_touch (
    .cfg           (cfg),
    .phase         (phase),
    .start_x       (start_x),
    .start_y       (start_y),
    .press_time    (press_time),
    .last_tap_time (last_tap_time),
    .pressed       (hold_p1),
    .pos_x         (hold_x),
    .pos_y         (hold_y),
    .time_ms       (hold_time),
    .dec           (tdec)
  );

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  assign active     = (hold_count != '0);
  assign two_finger = (hold_count >= 4'd2) && hold_p1 && hold_p2;

  assign cur_x_next   = (!two_finger && (tdec.cur_upd || tdec.load_start)) ? hold_x : cur_x;
  assign cur_y_next   = (!two_finger && (tdec.cur_upd || tdec.load_start)) ? hold_y : cur_y;
  assign emit         = active && (two_finger ? pdec.emit : tdec.emit);
  assign gesture_next = two_finger ? (pdec.outward ? G_PINCH_OUT : G_PINCH_IN) : tdec.gesture;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_count <= point_count;
      hold_p1    <= first_pressed;
      hold_x     <= first_x;
      hold_y     <= first_y;
      hold_p2    <= second_pressed;
      hold_x2    <= second_x;
      hold_y2    <= second_y;
      hold_time  <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      start_x       <= '0;
      start_y       <= '0;
      cur_x         <= '0;
      cur_y         <= '0;
      press_time    <= '0;
      last_tap_time <= '0;
      pinch_ref     <= '0;
    end else if (advance && active) begin
      if (two_finger) begin
        if (pdec.latch || pdec.emit) begin
          pinch_ref <= span_sq;
        end
      end else begin
        pinch_ref <= '0;
        phase     <= tdec.phase_next;
        cur_x     <= cur_x_next;
        cur_y     <= cur_y_next;
        if (tdec.load_start) begin
          start_x    <= hold_x;
          start_y    <= hold_y;
          press_time <= hold_time;
        end
        if (tdec.tap_store) begin
          last_tap_time <= hold_time;
        end else if (tdec.tap_clear) begin
          last_tap_time <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture    <= gesture_next;
      begin_x    <= start_x;
      begin_y    <= start_y;
      finish_x   <= cur_x_next;
      finish_y   <= cur_y_next;
      elapsed_ms <= hold_time - press_time;
    end
  end

endmodule

@@ sv/tgr_checker.sv @@
// ----------------------------------------------------------------------------
// tgr_checker
// port-level checks of the touch gesture recognizer, bound to the top level
// ----------------------------------------------------------------------------
`include "touch_gesture_recognizer_unit_defines.svh"

module tgr_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tgr_pkg::gesture_t gesture,
  input logic [31:0]       elapsed_ms
);
  import tgr_pkg::*;

  `TGR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output beat right after reset")
  `TGR_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with empty output")
  `TGR_ASSERT(a_gesture_code, out_valid |-> (gesture <= G_PINCH_OUT), "gesture code out of range")
  `TGR_ASSERT(a_result_hold, (out_valid && !out_ready) |=> (out_valid && $stable(gesture) && $stable(elapsed_ms)), "stalled result changed")

endmodule

bind touch_gesture_recognizer_unit tgr_checker u_tgr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .gesture    (gesture),
  .elapsed_ms (elapsed_ms)
);

@@ verif/touch_gesture_recognizer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_unit_tb
// self-checking bench for the touch gesture recognizer
// ----------------------------------------------------------------------------
// Touch reports are queued up by a stimulus process and sent by a clocked
// driver with random gaps. Every accepted report runs through a local model of
// the tap, double tap, long press, swipe and pinch logic, which queues the
// gesture it should cause. A clocked monitor with random back-pressure pops
// that queue for every output beat and compares all fields. The run starts
// with hand-picked corner sequences, then goes through several register
// settings (reset values, both extremes, a long output stall and random ones)
// with mostly well-formed finger sequences and some noise.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgr_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_CYCLES  = 300;
  localparam int STUCK_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 55;
  localparam int NUM_PHASES    = 7;

  typedef struct {
    logic [3:0]  pts;
    logic        p1;
    logic [11:0] x1;
    logic [11:0] y1;
    logic        p2;
    logic [11:0] x2;
    logic [11:0] y2;
    logic [31:0] ms;
  } touch_report_t;

  typedef struct {
    gesture_t    code;
    logic [11:0] bx;
    logic [11:0] by;
    logic [11:0] fx;
    logic [11:0] fy;
    logic [31:0] dur;
  } gesture_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  point_count = '0;
  logic        first_pressed = 1'b0;
  logic [11:0] first_x = '0;
  logic [11:0] first_y = '0;
  logic        second_pressed = 1'b0;
  logic [11:0] second_x = '0;
  logic [11:0] second_y = '0;
  logic [31:0] time_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  gesture_t    gesture;
  logic [11:0] begin_x;
  logic [11:0] begin_y;
  logic [11:0] finish_x;
  logic [11:0] finish_y;
  logic [31:0] elapsed_ms;

  touch_gesture_recognizer_unit uut (.*);

  // model registers and state
  logic [11:0] cfg_swipe = SWIPE_MIN_RESET;
  logic [15:0] cfg_long = LONG_PRESS_RESET;
  logic [15:0] cfg_dtap = DOUBLE_TAP_RESET;
  logic [6:0]  cfg_pct = PINCH_PCT_RESET;
  logic [1:0]  fsm_phase = PH_IDLE;
  logic [11:0] anchor_x = '0;
  logic [11:0] anchor_y = '0;
  logic [11:0] track_x = '0;
  logic [11:0] track_y = '0;
  logic [31:0] press_ms = '0;
  logic [31:0] last_tap_ms = '0;
  logic [24:0] pinch_ref = '0;

  touch_report_t report_queue[$];
  gesture_beat_t pending_gestures[$];
  touch_report_t tx_report;
  logic [31:0]   now_ms = '0;
  int            items_sent = 0;
  int            error_count = 0;
  int            send_gap = 0;
  int            rx_hold = 0;
  int            hold_request = 0;
  int            stuck_cycles = 0;
  bit            jitter_on = 1'b1;

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [11:0] clip(int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return v[11:0];
  endfunction

  function automatic longint dist_sq(longint ax, longint ay, longint bx, longint by);
    return (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  function automatic void emit_gesture(gesture_t code, logic [31:0] ms);
    gesture_beat_t g;
    g.code = code;
    g.bx = anchor_x;
    g.by = anchor_y;
    g.fx = track_x;
    g.fy = track_y;
    g.dur = ms - press_ms;
    pending_gestures.push_back(g);
  endfunction

  function automatic void recognize_report(touch_report_t r);
    longint d, ref_l, thr, sw, ax, ay, bx, by, dx, dy, adx, ady;
    logic [31:0] held, since;
    if (r.pts == 0) return;
    if (r.pts >= 2 && r.p1 && r.p2) begin
      d = dist_sq(r.x1, r.y1, r.x2, r.y2);
      ref_l = pinch_ref;
      if (ref_l == 0) begin
        pinch_ref = 25'(d);
      end else begin
        sw = cfg_pct;
        thr = (ref_l * sw) / 100;
        if (d > ref_l + thr) begin
          pinch_ref = 25'(d);
          emit_gesture(G_PINCH_OUT, r.ms);
        end else if (d < ref_l - thr) begin
          pinch_ref = 25'(d);
          emit_gesture(G_PINCH_IN, r.ms);
        end
      end
      return;
    end
    pinch_ref = '0;
    case (fsm_phase)
      PH_IDLE: begin
        if (r.p1) begin
          fsm_phase = PH_DOWN;
          anchor_x = r.x1;
          anchor_y = r.y1;
          track_x = r.x1;
          track_y = r.y1;
          press_ms = r.ms;
        end
      end
      PH_DOWN: begin
        track_x = r.x1;
        track_y = r.y1;
        if (!r.p1) begin
          fsm_phase = PH_IDLE;
          since = r.ms - last_tap_ms;
          if (last_tap_ms != 0 && since < cfg_dtap) begin
            last_tap_ms = '0;
            emit_gesture(G_DOUBLE, r.ms);
          end else begin
            last_tap_ms = r.ms;
            emit_gesture(G_TAP, r.ms);
          end
        end else begin
          sw = cfg_swipe;
          if (dist_sq(anchor_x, anchor_y, r.x1, r.y1) > (sw * sw) / 4) fsm_phase = PH_MOVING;
          held = r.ms - press_ms;
          if (held >= cfg_long) begin
            fsm_phase = PH_IDLE;
            emit_gesture(G_LONG, r.ms);
          end
        end
      end
      PH_MOVING: begin
        track_x = r.x1;
        track_y = r.y1;
        if (!r.p1) begin
          fsm_phase = PH_IDLE;
          ax = anchor_x;
          ay = anchor_y;
          bx = track_x;
          by = track_y;
          dx = bx - ax;
          dy = by - ay;
          adx = dx < 0 ? -dx : dx;
          ady = dy < 0 ? -dy : dy;
          sw = cfg_swipe;
          if (adx > ady && adx >= sw) emit_gesture(dx > 0 ? G_RIGHT : G_LEFT, r.ms);
          else if (ady >= adx && ady >= sw) emit_gesture(dy > 0 ? G_DOWN : G_UP, r.ms);
        end
      end
      default: fsm_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void push_report(logic [3:0] pts, logic p1, logic [11:0] x1, y1,
                                      logic p2, logic [11:0] x2, y2, logic [31:0] ms);
    touch_report_t r;
    r.pts = pts;
    r.p1 = p1;
    r.x1 = x1;
    r.y1 = y1;
    r.p2 = p2;
    r.x2 = x2;
    r.y2 = y2;
    r.ms = ms;
    report_queue.push_back(r);
    if (pts != 0) items_sent++;
  endfunction

  // one finger; extra points may be listed but the second one is lifted
  function automatic void push_single(logic p1, int x, int y);
    logic [3:0] pts;
    logic p2;
    if ($urandom_range(0, 4) != 0) begin
      pts = 4'd1;
      p2 = 1'($urandom);
    end else begin
      pts = 4'($urandom_range(2, 15));
      p2 = 1'b0;
    end
    push_report(pts, p1, clip(x), clip(y), p2, 12'($urandom), 12'($urandom), now_ms);
  endfunction

  function automatic void add_gesture_sequence();
    int r, x, y, ex, ey, len, wob, steps, ox, oy, f;
    logic [31:0] t0;
    logic [3:0] pts;
    logic pa, pb;
    r = $urandom_range(0, 99);
    if (r < 1) now_ms = '0;
    else if (r < 4) now_ms = $urandom();
    else if (r < 6) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
    x = $urandom_range(0, 4095);
    y = $urandom_range(0, 4095);
    r = $urandom_range(0, 99);
    if (r < 22) begin
      // tap, often a second one close behind
      repeat ($urandom_range(1, 2)) begin
        push_single(1'b1, x, y);
        now_ms += $urandom_range(0, 200);
        push_single(1'b0, x + jitter(3), y + jitter(3));
        now_ms += $urandom_range(0, int'(cfg_dtap) + 100);
      end
    end else if (r < 42) begin
      len = $urandom_range(0, 2 * int'(cfg_swipe) + 40);
      wob = jitter(len / 2);
      case ($urandom_range(0, 3))
        0: begin
          ex = x - len;
          ey = y + wob;
        end
        1: begin
          ex = x + len;
          ey = y + wob;
        end
        2: begin
          ex = x + wob;
          ey = y - len;
        end
        default: begin
          ex = x + wob;
          ey = y + len;
        end
      endcase
      steps = $urandom_range(1, 3);
      push_single(1'b1, x, y);
      for (int i = 1; i <= steps; i++) begin
        now_ms += $urandom_range(1, 40);
        push_single(1'b1, x + (ex - x) * i / steps, y + (ey - y) * i / steps);
      end
      now_ms += $urandom_range(1, 40);
      push_single(1'b0, ex, ey);
    end else if (r < 54) begin
      // hold near still until just around the long press time
      t0 = now_ms;
      steps = $urandom_range(1, 3);
      push_single(1'b1, x, y);
      for (int i = 1; i <= steps; i++) begin
        now_ms = t0 + (32'(cfg_long) * i) / (steps + 1);
        push_single(1'b1, x + jitter(3), y + jitter(3));
      end
      now_ms = t0 + 32'(cfg_long) + $urandom_range(0, 30) - 1;
      push_single(1'b1, x + jitter(3), y + jitter(3));
      if ($urandom_range(0, 1) != 0) begin
        now_ms += $urandom_range(1, 50);
        push_single(1'b0, x, y);
      end
    end else if (r < 74) begin
      ox = jitter(750);
      oy = jitter(750);
      steps = $urandom_range(2, 6);
      for (int i = 0; i < steps; i++) begin
        f = $urandom_range(40, 160);
        pts = ($urandom_range(0, 4) != 0) ? 4'd2 : 4'($urandom_range(3, 15));
        pa = 1'b1;
        pb = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          pa = 1'($urandom);
          pb = 1'($urandom);
        end
        push_report(pts, pa, clip(x), clip(y), pb, clip(x + ox * f / 100),
                    clip(y + oy * f / 100), now_ms);
        now_ms += $urandom_range(1, 30);
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        push_report(4'($urandom), 1'($urandom), 12'($urandom), 12'($urandom),
                    1'($urandom), 12'($urandom), 12'($urandom),
                    ($urandom_range(0, 1) != 0) ? now_ms : 32'($urandom));
        now_ms += $urandom_range(0, 100);
      end
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (report_queue.size() != 0 || in_valid || pending_gestures.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SWIPE_MIN:  cfg_swipe = data[11:0];
      CFG_LONG_PRESS: cfg_long = data;
      CFG_DOUBLE_TAP: cfg_dtap = data;
      CFG_PINCH_PCT:  cfg_pct = data[6:0];
    endcase
  endtask

  task automatic set_config(logic [15:0] sw, logic [15:0] lp, logic [15:0] dt,
                            logic [15:0] pc);
    write_reg(CFG_SWIPE_MIN, sw);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_DOUBLE_TAP, dt);
    write_reg(CFG_PINCH_PCT, pc);
  endtask

  // report driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) recognize_report(tx_report);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (report_queue.size() > 0) begin
          tx_report = report_queue.pop_front();
          point_count <= tx_report.pts;
          first_pressed <= tx_report.p1;
          first_x <= tx_report.x1;
          first_y <= tx_report.y1;
          second_pressed <= tx_report.p2;
          second_x <= tx_report.x2;
          second_y <= tx_report.y2;
          time_ms <= tx_report.ms;
          in_valid <= 1'b1;
          send_gap = jitter_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_gesture();
    gesture_beat_t want;
    if (pending_gestures.size() == 0) begin
      note_error($sformatf("unexpected gesture beat: code %0d (%0d,%0d)->(%0d,%0d) dur %0d",
                           gesture, begin_x, begin_y, finish_x, finish_y, elapsed_ms));
      return;
    end
    want = pending_gestures.pop_front();
    if (gesture !== want.code || begin_x !== want.bx || begin_y !== want.by ||
        finish_x !== want.fx || finish_y !== want.fy || elapsed_ms !== want.dur)
      note_error($sformatf(
        "gesture mismatch: exp %0d (%0d,%0d)->(%0d,%0d) dur %0d, got %0d (%0d,%0d)->(%0d,%0d) dur %0d",
        want.code, want.bx, want.by, want.fx, want.fy, want.dur,
        gesture, begin_x, begin_y, finish_x, finish_y, elapsed_ms));
  endfunction

  // gesture monitor with back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) check_gesture();
      if (hold_request > 0) begin
        rx_hold = hold_request;
        hold_request = 0;
      end else if (rx_hold == 0 && jitter_on && $urandom_range(0, 3) == 0) begin
        rx_hold = pick_gap() + 1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // no beat on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero point count is ignored
    push_report(4'd0, 1'b1, 12'd4095, 12'd4095, 1'b1, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    // tap at time zero leaves no prior tap
    push_report(4'd1, 1'b1, 12'd100, 12'd100, 1'b0, 12'd0, 12'd0, 32'd0);
    push_report(4'd1, 1'b0, 12'd100, 12'd100, 1'b0, 12'd0, 12'd0, 32'd0);
    push_report(4'd1, 1'b1, 12'd200, 12'd200, 1'b1, 12'd7, 12'd9, 32'd10);
    push_report(4'd1, 1'b0, 12'd201, 12'd199, 1'b0, 12'd0, 12'd0, 32'd50);
    // double tap
    push_report(4'd1, 1'b1, 12'd210, 12'd210, 1'b0, 12'd0, 12'd0, 32'd100);
    push_report(4'd1, 1'b0, 12'd210, 12'd210, 1'b0, 12'd0, 12'd0, 32'd200);
    // long press
    push_report(4'd1, 1'b1, 12'd0, 12'd0, 1'b0, 12'd0, 12'd0, 32'd1000);
    push_report(4'd1, 1'b1, 12'd1, 12'd1, 1'b0, 12'd0, 12'd0, 32'd1400);
    // full width swipe right
    push_report(4'd1, 1'b1, 12'd0, 12'd2048, 1'b0, 12'd0, 12'd0, 32'd2000);
    push_report(4'd1, 1'b1, 12'd4095, 12'd2048, 1'b0, 12'd0, 12'd0, 32'd2010);
    push_report(4'd1, 1'b0, 12'd4095, 12'd2048, 1'b0, 12'd0, 12'd0, 32'd2020);
    // moving but released short of the swipe distance
    push_report(4'd1, 1'b1, 12'd1000, 12'd1000, 1'b0, 12'd0, 12'd0, 32'd3000);
    push_report(4'd1, 1'b1, 12'd1030, 12'd1000, 1'b0, 12'd0, 12'd0, 32'd3010);
    push_report(4'd1, 1'b0, 12'd1030, 12'd1000, 1'b0, 12'd0, 12'd0, 32'd3020);
    // zero distance stays unlatched, then latch the widest spread
    push_report(4'd2, 1'b1, 12'd0, 12'd0, 1'b1, 12'd0, 12'd0, 32'd4000);
    push_report(4'd2, 1'b1, 12'd0, 12'd0, 1'b1, 12'd4095, 12'd4095, 32'd4010);
    push_report(4'd15, 1'b1, 12'd0, 12'd0, 1'b1, 12'd100, 12'd100, 32'd4020);
    push_report(4'd2, 1'b1, 12'd0, 12'd0, 1'b1, 12'd4095, 12'd4095, 32'd4030);
    // second finger lifted clears the pinch reference
    push_report(4'd2, 1'b1, 12'd0, 12'd0, 1'b0, 12'd4095, 12'd4095, 32'd4040);
    push_report(4'd3, 1'b1, 12'd0, 12'd4095, 1'b1, 12'd0, 12'd0, 32'd4050);
    push_report(4'd1, 1'b0, 12'd0, 12'd4095, 1'b1, 12'd4095, 12'd0, 32'd4060);
    now_ms = 32'd5000;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: set_config(16'd0, 16'd0, 16'd0, 16'd0);
        2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_config(16'd20, 16'd150, 16'd500, 16'd100);
        4, 5: set_config({4'($urandom), 12'($urandom_range(0, 200))},
                         16'($urandom_range(50, 1000)), 16'($urandom_range(50, 1000)),
                         {9'($urandom), 7'($urandom_range(0, 127))});
        6: set_config(16'(SWIPE_MIN_RESET), LONG_PRESS_RESET, DOUBLE_TAP_RESET,
                      16'(PINCH_PCT_RESET));
        default: ;
      endcase
      @(negedge clk);
      jitter_on = (ph % 2 == 0);
      // long output stall while reports keep coming
      if (ph == 3) hold_request = STALL_CYCLES;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) add_gesture_sequence();
    end

    wait_idle();
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
